[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, held off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ili_pkg.sv]
`timescale 1ns / 1ps
package ili_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int STATUS_W     = 2;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 32;
  localparam int OUT_TUSER_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEM    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic capture;
    logic insert;
    logic emit_err;
    logic emit_elem;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_bad;
    logic list_full;
    logic out_free;
    logic rev_end;
  } dp_status_t;

endpackage

[design/ili_ctrl.sv]
`timescale 1ns / 1ps
module ili_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ili_pkg::dp_status_t stat,
  output ili_pkg::dp_cmd_t   cmd
);
  import ili_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.pos_bad || stat.list_full) begin
          if (stat.out_free) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        if (stat.out_free && stat.rev_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        if (stat.pos_bad || stat.list_full) begin
          cmd.emit_err = stat.out_free;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      S_STREAM: begin
        cmd.emit_elem = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[design/ili_dp.sv]
`timescale 1ns / 1ps
module ili_dp #(
  parameter int CAPACITY = ili_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ili_pkg::IN_TDATA_W-1:0] in_data,
  input  ili_pkg::dp_cmd_t               cmd,
  output ili_pkg::dp_status_t            stat,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic [ili_pkg::OUT_TDATA_W-1:0] m_data,
  output logic [ili_pkg::OUT_TUSER_W-1:0] m_user,
  output logic                           m_last
);
  import ili_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] list_q [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic              dir;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              fwd_end;
  logic              load;

  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count);
  assign fwd_end = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign load    = cmd.emit_err || cmd.emit_elem;

  assign stat.pos_bad   = pos_ext > cnt_ext;
  assign stat.list_full = count == CAP_CNT;
  assign stat.out_free  = !m_valid || m_ready;
  assign stat.rev_end   = dir && (idx == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_q <= in_data[POS_W-1:0];
      val_q <= in_data[POS_W +: DATA_W];
    end
  end

  // Every entry above the insert point takes its lower neighbor in the same cycle.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    localparam logic [CMP_W-1:0] I_C = CMP_W'(i);
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && (I_C == pos_ext)) begin
          list_q[i] <= val_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (I_C == pos_ext) begin
            list_q[i] <= val_q;
          end else if (I_C > pos_ext) begin
            list_q[i] <= list_q[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      dir   <= 1'b0;
    end else if (cmd.insert) begin
      count <= count + CNT_W'(1);
      idx   <= '0;
      dir   <= 1'b0;
    end else if (cmd.emit_elem) begin
      // The reverse pass starts on the tail entry the forward pass ended on.
      if (!dir) begin
        if (fwd_end) begin
          dir <= 1'b1;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end else begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      m_data <= '0;
      m_user <= {1'b0, (stat.pos_bad ? ST_INVALID : ST_FULL)};
      m_last <= 1'b1;
    end else if (cmd.emit_elem) begin
      m_data <= list_q[idx];
      m_user <= {dir, ST_ELEM};
      m_last <= stat.rev_end;
    end
  end

endmodule

[design/indexed_list_insert_core.sv]
`timescale 1ns / 1ps
// Channel   Dir  tdata                               tuser                     tlast
// s_axis    in   [4:0] position, [36:5] value         -                         -
// m_axis    out  [31:0] element                      [1:0] status, [2] direction  last
//
// An accepted insert gives 2n result words, n being the new count: the idle state
// takes the word, the exec state checks it and shifts the list registers, then one
// result word per cycle leaves the output register unless it is stalled. A rejected
// word gives one status word. A stalled output holds the stream where it is; no new
// word is taken until the last result is loaded. Reset clears the count, not the list.
module indexed_list_insert_core #(
  parameter int CAPACITY = ili_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ili_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // position, value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ili_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // element
  output logic [ili_pkg::OUT_TUSER_W-1:0] m_axis_tuser,  // status, direction
  output logic                            m_axis_tlast
);
  import ili_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  ili_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ili_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_axis_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_user  (m_axis_tuser),
    .m_last  (m_axis_tlast)
  );

endmodule

[design/ili_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ili_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ili_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [ili_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                            m_axis_tlast
);
  import ili_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic                out_dir;
  logic                out_hold;
  logic                in_take;
  logic                err_word;
  logic                err_clean;
  logic                elem_end;

  assign out_status = m_axis_tuser[STATUS_W-1:0];
  assign out_dir    = m_axis_tuser[STATUS_W];
  assign out_hold   = m_axis_tvalid && !m_axis_tready;
  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign err_word   = m_axis_tvalid && (out_status != ST_ELEM);
  assign err_clean  = m_axis_tlast && (m_axis_tdata == '0) && !out_dir;
  assign elem_end   = m_axis_tvalid && m_axis_tlast && (out_status == ST_ELEM);

  `ASSERT_CLK(a_out_hold, out_hold |=> m_axis_tvalid && $stable(m_axis_tdata), "held word changed")

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output word present after reset")

  `ASSERT_CLK(a_one_at_a_time, in_take |=> !s_axis_tready, "input taken mid-insert")

  `ASSERT_CLK(a_status_word, err_word |-> err_clean, "status word not a lone zero word")

  `ASSERT_CLK(a_last_reverse, elem_end |-> out_dir, "list stream ended in the forward pass")

endmodule

bind indexed_list_insert_core ili_checker u_ili_checker (.*);
